### design/ckbr_pkg.sv
// shared types, register indexes and hash helpers for the canonical k-mer bucket router
// no dependencies; used by the top level and its port checker
package ckbr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COVERAGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COVERAGE = 2'd3;

    localparam logic [5:0]  RST_KMER_LENGTH  = 6'd30;
    localparam logic [3:0]  RST_BUCKET_BITS  = 4'd7;
    localparam logic [23:0] RST_MIN_COVERAGE = 24'd1;
    localparam logic [23:0] RST_MAX_COVERAGE = 24'd0;

    localparam logic [5:0] K_MAX      = 6'd32;
    localparam logic [5:0] SEEN_MAX   = 6'd63;

    localparam int MIX_SHL_A = 13;
    localparam int MIX_SHR   = 17;
    localparam int MIX_SHL_B = 15;

    typedef struct packed {
        logic [1:0]  base;
        logic        last_base;
        logic [23:0] coverage;
    } t_in_item;

    typedef struct packed {
        logic        list_side;
        logic [14:0] bucket;
        logic [63:0] kmer_code;
        logic [31:0] sequence_number;
        logic        last_of_run;
    } t_out_item;

    // 32-bit xorshift
    function automatic logic [31:0] mix32(input logic [31:0] y);
        logic [31:0] t;
        t = y ^ (y << MIX_SHL_A);
        t = t ^ (t >> MIX_SHR);
        t = t ^ (t << MIX_SHL_B);
        return t;
    endfunction

    // zero acts as one, anything above 32 acts as 32
    function automatic logic [5:0] eff_k(input logic [5:0] len);
        logic [5:0] k;
        if (len == 6'd0) begin
            k = 6'd1;
        end else if (len > K_MAX) begin
            k = K_MAX;
        end else begin
            k = len;
        end
        return k;
    endfunction

endpackage

### design/canonical_kmer_bucket_router.sv
// canonical k-mer bucket router: rolling windows, coverage filter, end k-mer hashing
// depends on ckbr_pkg
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_in  (t_in_item)
//  output  | out       | o_valid / i_ready  | o_out (t_out_item)
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one base is taken per cycle while o_ready is high; the windows and counters update at acceptance
// an item with results sits in one result stage, then a registered output slot
// a sequence of exactly k bases that passes the filter gives two results, so its final base
// holds the input until the begin result leaves; other items hold it only through output stalls
// synchronous active-low reset clears the control state and loads the register defaults;
// the result data registers are not reset; output stalls back up through the result stage to o_ready
module canonical_kmer_bucket_router (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ckbr_pkg::t_in_item                  i_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output ckbr_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [ckbr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ckbr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ckbr_pkg::*;

    logic [5:0]  r_kmer_length;
    logic [3:0]  r_bucket_bits;
    logic [23:0] r_min_cov;
    logic [23:0] r_max_cov;

    logic [63:0] r_fwd;
    logic [63:0] r_rev;
    logic [5:0]  r_seen;
    logic [31:0] r_next_number;
    logic        r_accepted;

    logic        r_a_valid;
    logic        r_a_begin;
    logic        r_a_end;
    logic [63:0] r_a_fwd;
    logic [63:0] r_a_rev;
    logic [31:0] r_a_number;

    logic        r_o_valid;
    t_out_item   r_o_item;

    logic [5:0]  k_eff;
    logic        in_acc;
    logic [63:0] n_fwd;
    logic [63:0] n_rev;
    logic [5:0]  n_seen;
    logic        hit_k;
    logic        drop;
    logic        n_accepted;
    logic        begin_now;
    logic        end_now;

    logic        o_load;
    logic        a_done;
    logic [6:0]  two_k;
    logic [63:0] kmask;
    logic [63:0] a_fwd_cut;
    logic [63:0] a_rc;
    logic        fwd_small;
    logic [63:0] canon;
    logic [31:0] hash;
    logic [14:0] bmask;
    t_out_item   n_o_item;

    assign k_eff  = eff_k(r_kmer_length);
    assign in_acc = i_valid && o_ready;

    // ---------------- input side ----------------
    always_comb begin
        n_fwd      = {r_fwd[61:0], i_in.base};
        n_rev      = {~i_in.base, r_rev[63:2]};
        n_seen     = (r_seen == SEEN_MAX) ? r_seen : r_seen + 6'd1;
        hit_k      = (n_seen == k_eff);
        drop       = ((r_min_cov > 24'd1) && (i_in.coverage < r_min_cov)) ||
                     ((r_max_cov != 24'd0) && (i_in.coverage > r_max_cov));
        n_accepted = hit_k ? !drop : r_accepted;
        begin_now  = hit_k && !drop;
        end_now    = i_in.last_base && n_accepted && (n_seen >= k_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= RST_KMER_LENGTH;
            r_bucket_bits <= RST_BUCKET_BITS;
            r_min_cov     <= RST_MIN_COVERAGE;
            r_max_cov     <= RST_MAX_COVERAGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KMER_LENGTH:  r_kmer_length <= i_cfg_data[5:0];
                CFG_BUCKET_BITS:  r_bucket_bits <= i_cfg_data[3:0];
                CFG_MIN_COVERAGE: r_min_cov     <= i_cfg_data;
                CFG_MAX_COVERAGE: r_max_cov     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd         <= '0;
            r_rev         <= '0;
            r_seen        <= '0;
            r_next_number <= '0;
            r_accepted    <= 1'b0;
        end else if (in_acc) begin
            if (i_in.last_base) begin
                r_fwd      <= '0;
                r_rev      <= '0;
                r_seen     <= '0;
                r_accepted <= 1'b0;
                if (n_accepted) begin
                    r_next_number <= r_next_number + 32'd1;
                end
            end else begin
                r_fwd      <= n_fwd;
                r_rev      <= n_rev;
                r_seen     <= n_seen;
                r_accepted <= n_accepted;
            end
        end
    end

    // ---------------- result stage ----------------
    assign o_load  = r_a_valid && (!r_o_valid || i_ready);
    // begin with a pending end keeps the stage for one more result
    assign a_done  = o_load && !(r_a_begin && r_a_end);
    assign o_ready = !r_a_valid || a_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_begin <= 1'b0;
            r_a_end   <= 1'b0;
        end else if (in_acc && (begin_now || end_now)) begin
            r_a_valid <= 1'b1;
            r_a_begin <= begin_now;
            r_a_end   <= end_now;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
        end else if (o_load) begin
            r_a_begin <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (begin_now || end_now)) begin
            r_a_fwd    <= n_fwd;
            r_a_rev    <= n_rev;
            r_a_number <= r_next_number;
        end
    end

    always_comb begin
        two_k     = {k_eff, 1'b0};
        kmask     = ~({64{1'b1}} << two_k);
        a_fwd_cut = r_a_fwd & kmask;
        a_rc      = r_a_rev >> (7'd64 - two_k);
        fwd_small = (a_fwd_cut <= a_rc);
        canon     = fwd_small ? a_fwd_cut : a_rc;
        hash      = mix32(canon[31:0]);
        bmask     = 15'((16'd1 << r_bucket_bits) - 16'd1);

        n_o_item.list_side       = (fwd_small == !r_a_begin);
        n_o_item.bucket          = hash[14:0] & bmask;
        n_o_item.kmer_code       = canon;
        n_o_item.sequence_number = r_a_number;
        n_o_item.last_of_run     = r_a_begin ? !r_a_end : 1'b1;
    end

    // ---------------- output slot ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o_item;

endmodule

### design/ckbr_checker.sv
// port-level checks for the canonical k-mer bucket router, bound to the top level
// depends on ckbr_pkg
module ckbr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_ready,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  ckbr_pkg::t_out_item                 o_out
);
    import ckbr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a non-final result is always followed by another one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last_of_run |=> o_valid)
        else $error("result run broken");

    // begin and end of one k-mer pair share code and number
    a_pair_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_out.last_of_run |=>
            o_out.last_of_run && o_out.list_side != $past(o_out.list_side) &&
            o_out.kmer_code == $past(o_out.kmer_code) &&
            o_out.sequence_number == $past(o_out.sequence_number))
        else $error("end result does not match begin result");

    // the pending end result blocks new items while the begin is stalled
    a_pair_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last_of_run && !i_ready |-> !o_ready)
        else $error("item taken while pair result pending");

endmodule

bind canonical_kmer_bucket_router ckbr_checker u_ckbr_checker (.*);
